[design/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// No dependencies; fbpa_div and the top level refer to it by scoped names.
package fbpa_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ADDR_W     = 32;
   localparam int OBJ_W      = 16;
   localparam int ALIGN_W    = 13;
   localparam int PROD_W     = IDX_W + OBJ_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_REBUILD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_ALGN = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] block_address;
   } fbpa_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic              status;
      logic [ADDR_W-1:0] used_bytes;
   } fbpa_rsp_type;

   // one entry of the freed-block link store
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
   } fbpa_link_type;

   localparam int LINK_W = $bits(fbpa_link_type);

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [OBJ_W-1:0]  divisor;
   } fbpa_div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [OBJ_W-1:0]  remainder;
   } fbpa_div_res_type;

endpackage

[design/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on fbpa_pkg for the request and result structs.
module fbpa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  fbpa_pkg::fbpa_div_req_type div_req,
   output fbpa_pkg::fbpa_div_res_type div_res
);

   localparam int STEP_W = $clog2(fbpa_pkg::ADDR_W + 1);

   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [fbpa_pkg::ADDR_W-1:0] quo_ff, quo_in;
   logic [fbpa_pkg::OBJ_W-1:0]  rem_ff, rem_in;
   logic [fbpa_pkg::OBJ_W-1:0]  dvs_ff, dvs_in;
   logic [fbpa_pkg::OBJ_W:0]    shifted;
   logic [fbpa_pkg::OBJ_W:0]    diff;

   assign shifted = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         step_in = STEP_W'(fbpa_pkg::ADDR_W);
         busy_in = 1'b1;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[fbpa_pkg::OBJ_W-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[fbpa_pkg::OBJ_W-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_res.done      = done_ff;
   assign div_res.quotient  = quo_ff;
   assign div_res.remainder = rem_ff;

endmodule

[design/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: control sequencer and pool state.
// Depends on fbpa_pkg, fbpa_ram (freed-block links) and fbpa_div (shared divider).
//
// Use: program pool_base, pool_size, object_size and object_alignment on the
// csr_ port (csr_ready is always high), then send a rebuild beat on req_.
// Each req_ beat (allocate, free, rebuild) yields exactly one rsp_ beat with
// the allocated address, the no-capacity status and the used-byte count.
// Items are handled one at a time; req_stall is high while an item is in work.
// From acceptance to rsp_valid, allocate steps through the link read (for a
// freed block), then multiply, then add; free makes one pass of the
// one-bit-per-cycle divider and rebuild two (one when no block fits). The
// next req_ beat can be taken in the same cycle that rsp_valid rises.
// Unknown request codes, no-capacity allocates and frees with object_size
// zero go straight to the response.
// The result sits in an output register: while rsp_stall is high the next
// item is still accepted and worked on, and only its result waits.
// Reset is synchronous: the pool is empty (allocate reports no capacity until
// a rebuild), registers take their defaults, and no link store clearing pass
// is needed since a link is read only after the free that wrote it.
module fixed_block_pool_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fbpa_pkg::fbpa_req_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fbpa_pkg::fbpa_rsp_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]         csr_data
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ALLOC_MUL = 3'd1;
   localparam logic [2:0] S_ALLOC_ADD = 3'd2;
   localparam logic [2:0] S_FREE_DIV  = 3'd3;
   localparam logic [2:0] S_REB_MOD   = 3'd4;
   localparam logic [2:0] S_REB_DIV   = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   localparam int IW = fbpa_pkg::IDX_W;
   localparam int CW = fbpa_pkg::CNT_W;
   localparam int AW = fbpa_pkg::ADDR_W;
   localparam int OW = fbpa_pkg::OBJ_W;
   localparam int LW = fbpa_pkg::ALIGN_W;
   localparam int PW = fbpa_pkg::PROD_W;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] base_ff;
   logic [AW-1:0] size_ff;
   logic [OW-1:0] obj_ff;
   logic [LW-1:0] align_ff;
   logic          freed_valid_ff, freed_valid_in;
   logic [IW-1:0] freed_head_ff, freed_head_in;
   logic [CW-1:0] fresh_next_ff, fresh_next_in;
   logic [CW-1:0] block_count_ff, block_count_in;
   logic [AW-1:0] first_addr_ff, first_addr_in;
   logic [AW-1:0] used_total_ff, used_total_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          pop_ff, pop_in;
   logic [IW-1:0] alloc_idx_ff, alloc_idx_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          below_ff, below_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic          status_ff, status_in;
   fbpa_pkg::fbpa_rsp_type rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic [LW-1:0]              align_eff;
   logic [LW-1:0]              adj;
   logic                       ram_wr;
   logic                       ram_rd;
   logic [IW-1:0]              ram_wr_addr;
   fbpa_pkg::fbpa_link_type     ram_wr_link;
   logic [fbpa_pkg::LINK_W-1:0] ram_rd_data;
   fbpa_pkg::fbpa_link_type     ram_rd_link;
   fbpa_pkg::fbpa_div_req_type  div_req;
   fbpa_pkg::fbpa_div_res_type  div_res;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign align_eff   = (align_ff == '0) ? LW'(1) : align_ff;
   assign adj         = (div_res.remainder == '0) ? '0 :
                        align_eff - div_res.remainder[LW-1:0];
   assign ram_rd_link = fbpa_pkg::fbpa_link_type'(ram_rd_data);

   fbpa_ram #(
      .WIDTH (fbpa_pkg::LINK_W),
      .DEPTH (fbpa_pkg::MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_link),
      .rd_en   (ram_rd),
      .rd_addr (freed_head_ff),
      .rd_data (ram_rd_data)
   );

   fbpa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   always_comb begin
      state_in       = state_ff;
      freed_valid_in = freed_valid_ff;
      freed_head_in  = freed_head_ff;
      fresh_next_in  = fresh_next_ff;
      block_count_in = block_count_ff;
      first_addr_in  = first_addr_ff;
      used_total_in  = used_total_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      pop_in         = pop_ff;
      alloc_idx_in   = alloc_idx_ff;
      prod_in        = prod_ff;
      below_in       = below_ff;
      res_addr_in    = res_addr_ff;
      status_in      = status_ff;
      rsp_data_in    = rsp_data_ff;
      ram_wr         = 1'b0;
      ram_rd         = 1'b0;
      ram_wr_addr    = div_res.quotient[IW-1:0];
      ram_wr_link    = '{vld: freed_valid_ff, idx: freed_head_ff};
      div_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_addr_in = '0;
               status_in   = 1'b0;
               case (req_data.req_type)
                  fbpa_pkg::REQ_ALLOC: begin
                     if (freed_valid_ff) begin
                        ram_rd       = 1'b1;
                        alloc_idx_in = freed_head_ff;
                        pop_in       = 1'b1;
                        state_in     = S_ALLOC_MUL;
                     end else if (fresh_next_ff < block_count_ff) begin
                        alloc_idx_in  = fresh_next_ff[IW-1:0];
                        fresh_next_in = fresh_next_ff + CW'(1);
                        pop_in        = 1'b0;
                        state_in      = S_ALLOC_MUL;
                     end else begin
                        status_in = 1'b1;
                        state_in  = S_RESP;
                     end
                  end
                  fbpa_pkg::REQ_FREE: begin
                     if (obj_ff != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req_data.block_address - first_addr_ff;
                        div_req.divisor  = obj_ff;
                        below_in         = req_data.block_address < first_addr_ff;
                        state_in         = S_FREE_DIV;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  fbpa_pkg::REQ_REBUILD: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = base_ff;
                     div_req.divisor  = OW'(align_eff);
                     state_in         = S_REB_MOD;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_ALLOC_MUL: begin
            prod_in       = PW'(alloc_idx_ff) * PW'(obj_ff);
            used_total_in = used_total_ff + AW'(obj_ff);
            if (pop_ff) begin
               freed_valid_in = ram_rd_link.vld;
               freed_head_in  = ram_rd_link.idx;
            end
            state_in = S_ALLOC_ADD;
         end
         S_ALLOC_ADD: begin
            res_addr_in = first_addr_ff + AW'(prod_ff);
            state_in    = S_RESP;
         end
         S_FREE_DIV: begin
            if (div_res.done) begin
               if (!below_ff && (div_res.quotient < AW'(block_count_ff))) begin
                  ram_wr         = 1'b1;
                  freed_head_in  = div_res.quotient[IW-1:0];
                  freed_valid_in = 1'b1;
                  used_total_in  = used_total_ff - AW'(obj_ff);
               end
               state_in = S_RESP;
            end
         end
         S_REB_MOD: begin
            if (div_res.done) begin
               first_addr_in  = base_ff + AW'(adj);
               fresh_next_in  = '0;
               freed_valid_in = 1'b0;
               freed_head_in  = '0;
               used_total_in  = '0;
               if ((AW'(adj) <= size_ff) && (obj_ff != '0)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = size_ff - AW'(adj);
                  div_req.divisor  = obj_ff;
                  state_in         = S_REB_DIV;
               end else begin
                  block_count_in = '0;
                  state_in       = S_RESP;
               end
            end
         end
         S_REB_DIV: begin
            if (div_res.done) begin
               if (div_res.quotient > AW'(fbpa_pkg::MAX_BLOCKS)) begin
                  block_count_in = CW'(fbpa_pkg::MAX_BLOCKS);
               end else begin
                  block_count_in = div_res.quotient[CW-1:0];
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_address = res_addr_ff;
               rsp_data_in.status         = status_ff;
               rsp_data_in.used_bytes     = used_total_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         base_ff        <= '0;
         size_ff        <= '0;
         obj_ff         <= OW'(16);
         align_ff       <= LW'(8);
         freed_valid_ff <= 1'b0;
         freed_head_ff  <= '0;
         fresh_next_ff  <= '0;
         block_count_ff <= '0;
         first_addr_ff  <= '0;
         used_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         freed_valid_ff <= freed_valid_in;
         freed_head_ff  <= freed_head_in;
         fresh_next_ff  <= fresh_next_in;
         block_count_ff <= block_count_in;
         first_addr_ff  <= first_addr_in;
         used_total_ff  <= used_total_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fbpa_pkg::CSR_POOL_BASE:   base_ff  <= csr_data;
               fbpa_pkg::CSR_POOL_SIZE:   size_ff  <= csr_data;
               fbpa_pkg::CSR_OBJECT_SIZE: obj_ff   <= csr_data[OW-1:0];
               fbpa_pkg::CSR_OBJECT_ALGN: align_ff <= csr_data[LW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pop_ff       <= pop_in;
      alloc_idx_ff <= alloc_idx_in;
      prod_ff      <= prod_in;
      below_ff     <= below_in;
      res_addr_ff  <= res_addr_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_fresh_within_count: assert property (@(posedge clock) disable iff (reset)
      fresh_next_ff <= block_count_ff)
      else $error("fresh block index beyond block count");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      block_count_ff <= CW'(fbpa_pkg::MAX_BLOCKS))
      else $error("block count above pool capacity");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_FREE_DIV || state_ff == S_REB_MOD ||
                        state_ff == S_REB_DIV))
      else $error("divider finished with no operation waiting");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |-> (rsp_data_ff.result_address == '0))
      else $error("no-capacity beat carries an address");

   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> !ram_rd)
      else $error("link store read and written in one cycle");

endmodule
